>>> hw/rtl/mtg_pkg.sv
// Shared constants, the tempering function and the index wrap function for the Mersenne Twister block.
// No dependencies; imported by mersenne_twister_generator_unit.
package mtg_pkg;

    localparam int          MT_DEPTH    = 624;
    localparam int          MT_IW       = 10;
    localparam logic [9:0]  MT_N        = 10'd624;
    localparam logic [9:0]  MT_LAST     = 10'd623;
    localparam logic [9:0]  MT_M        = 10'd397;
    localparam logic [31:0] MT_MATRIX   = 32'h9908_B0DF;
    localparam logic [31:0] MT_TEMPER_B = 32'h9D2C_5680;
    localparam logic [31:0] MT_TEMPER_C = 32'hEFC6_0000;
    localparam logic [31:0] MT_LOW_MASK = 32'h7FFF_FFFF;
    localparam logic [31:0] MT_UP_MASK  = 32'h8000_0000;
    localparam logic [31:0] MT_ODD_STEP = 32'd527;
    localparam logic [31:0] MT_EVEN_MUL = 32'd74111;
    localparam logic [31:0] MT_EVEN_OFS = 32'd2135;

    // Standard MT19937 output tempering
    function automatic logic [31:0] mt_temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Index wrap for a sum known to stay below twice the depth
    function automatic logic [9:0] mt_wrap(input logic [9:0] i);
        return (i >= MT_N) ? 10'(i - MT_N) : i;
    endfunction

endpackage

>>> hw/rtl/mersenne_twister_generator_unit.sv
// Top level of the Mersenne Twister generator: state store, sequencer, output register.
// Depends on mtg_pkg.
//
// Mersenne Twister (MT19937 twist and tempering) with a 624 x 32 state store held
// in a two-read, one-write memory. Every transfer on the input channel is either a
// draw (kind 0), which yields one signed Q1.31 value in [-1,1), or a reseed
// (kind 1), which yields nothing. The block takes one item at a time and holds
// o_stall high while it works. A draw steps through accept, read of entries k and
// k+1, read of entry k+397, and twist/write/temper; the three reads over two read
// ports set that sequence. A reseed makes one store write per cycle for the fill,
// then runs a twist pass that reuses the draw's read-read-write sequence for every
// entry in turn. After reset the block runs a clearing pass over the store with
// o_stall high before the first item. The result sits in an output register, so a
// draw result may wait on i_stall while the next item is already accepted; a
// following draw then waits in its write step until that earlier result has been
// transferred.
module mersenne_twister_generator_unit
    import mtg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic [31:0]        i_seed,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,   // sequential write of the store (seed formula or zero)
        S_RD0,    // read entries k and k+1
        S_RD1,    // latch mixed word, read entry k+397
        S_TWIST   // write twisted entry; for a draw, temper and present result
    } t_state;

    t_state        r_state;
    logic          r_clear;      // fill writes zeros (post-reset clearing)
    logic          r_pass;       // twist pass of a reseed, as opposed to a draw
    logic [9:0]    r_k;
    logic [9:0]    r_index;
    logic [31:0]   r_odd_acc;    // seed + i*527
    logic [31:0]   r_even_acc;   // (2135 + seed*74111) * i
    logic [31:0]   r_even_step;
    logic [31:0]   r_y;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [31:0]   r_value;

    // state store
    logic [31:0]   r_mem [MT_DEPTH];
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_b;

    logic [9:0]    w_nxt;
    logic [9:0]    w_far;
    logic [9:0]    w_ra;
    logic          w_we;
    logic [31:0]   w_wd;
    logic [31:0]   w_fill;
    logic [31:0]   w_new;
    logic          w_go;

    assign w_nxt  = mt_wrap(10'(r_k + 10'd1));
    assign w_far  = mt_wrap(10'(r_k + MT_M));
    // keep entry k+397 on port A while the write step waits
    assign w_ra   = ((r_state == S_RD1) || (r_state == S_TWIST)) ? w_far : r_k;

    assign w_fill = r_clear ? 32'd0 : (r_k[0] ? r_odd_acc : r_even_acc);
    assign w_new  = r_rd_a ^ (r_y >> 1) ^ (r_y[0] ? MT_MATRIX : 32'd0);

    // a draw may only finish once the output register is free or its result is being transferred
    assign w_go   = r_pass || !r_out_valid || !i_stall;

    assign w_we   = (r_state == S_FILL) || ((r_state == S_TWIST) && w_go);
    assign w_wd   = (r_state == S_FILL) ? w_fill : w_new;

    // result register: loaded by a finishing draw, emptied by a transfer
    assign n_out_valid = ((r_state == S_TWIST) && w_go && !r_pass) ? 1'b1
                                                                    : (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_k] <= w_wd;
        end
        r_rd_a <= r_mem[w_ra];
        r_rd_b <= r_mem[w_nxt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_clear     <= 1'b1;
            r_pass      <= 1'b0;
            r_k         <= '0;
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_k <= i_kind ? 10'd0 : r_index;
                        if (i_kind) begin
                            r_odd_acc   <= i_seed;
                            r_even_acc  <= '0;
                            r_even_step <= 32'(MT_EVEN_OFS + 32'(i_seed * MT_EVEN_MUL));
                            r_clear     <= 1'b0;
                            r_state     <= S_FILL;
                        end else begin
                            r_pass  <= 1'b0;
                            r_state <= S_RD0;
                        end
                    end
                end
                S_FILL: begin
                    r_odd_acc  <= r_odd_acc + MT_ODD_STEP;
                    r_even_acc <= r_even_acc + r_even_step;
                    if (r_k == MT_LAST) begin
                        r_k <= '0;
                        if (r_clear) begin
                            r_clear <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= S_RD0;
                        end
                    end else begin
                        r_k <= 10'(r_k + 10'd1);
                    end
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_y     <= (r_rd_a & MT_UP_MASK) | (r_rd_b & MT_LOW_MASK);
                    r_state <= S_TWIST;
                end
                S_TWIST: begin
                    if (w_go) begin
                        if (r_pass) begin
                            if (r_k == MT_LAST) begin
                                r_index <= '0;
                                r_pass  <= 1'b0;
                                r_state <= S_IDLE;
                            end else begin
                                r_k     <= w_nxt;
                                r_state <= S_RD0;
                            end
                        end else begin
                            r_value <= mt_temper(w_new) ^ MT_UP_MASK;
                            r_index <= w_nxt;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_value = signed'(r_value);

endmodule

>>> sim/mersenne_twister_generator_unit_tb.sv
// Self-checking testbench for mersenne_twister_generator_unit: reseed and draw transfers,
// each draw checked against a behavioural copy of the twister held in this file.
// Depends on the RTL top level only (mtg_pkg is pulled in by the RTL itself).
module mersenne_twister_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Item kinds on the input channel
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    // Twister constants, kept local to the bench so the prediction stays independent
    localparam int unsigned TABLE_DEPTH = 624;
    localparam int unsigned FAR_OFFSET  = 397;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_MASK_B = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_MASK_C = 32'hEFC6_0000;
    localparam logic [31:0] LOWER_BITS  = 32'h7FFF_FFFF;
    localparam logic [31:0] UPPER_BIT   = 32'h8000_0000;
    localparam logic [31:0] ODD_STEP    = 32'd527;
    localparam logic [31:0] EVEN_MUL    = 32'd74111;
    localparam logic [31:0] EVEN_OFFSET = 32'd2135;

    localparam int RANDOM_ITEMS = 830;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic        kind;
        logic [31:0] seed;
    } t_mt_item;

    // DUT connections; every input has a known value from time zero
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               item_valid  = 1'b0;
    logic               item_kind   = KIND_DRAW;
    logic [31:0]        item_seed   = 32'h0;
    logic               item_stall;
    logic               value_valid;
    logic               value_stall = 1'b0;
    logic signed [31:0] rand_value;

    // Predicted twister state: cleared at reset, as the block clears its store
    logic [31:0] mt_words [TABLE_DEPTH];
    int unsigned mt_pos = 0;

    t_mt_item    pending_items[$];
    logic [31:0] expected_values[$];

    // Handshake bookkeeping shared between the rising-edge monitors and the
    // falling-edge drivers (never touched by both edges in the same step)
    int items_issued  = 0;
    int items_taken   = 0;
    int item_total    = 0;
    int values_seen   = 0;
    int values_acked  = 0;
    int send_wait     = 0;
    int send_quiet    = 0;
    int hold_wait     = 0;
    int recv_quiet    = 0;
    int fail_count    = 0;

    mersenne_twister_generator_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (item_valid),
        .o_stall (item_stall),
        .i_kind  (item_kind),
        .i_seed  (item_seed),
        .o_valid (value_valid),
        .i_stall (value_stall),
        .o_value (rand_value)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Single synchronous reset at the start; the block then runs its own
    // clearing pass with o_stall high, which the driver simply waits out.
    initial begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
    end

    initial begin
        foreach (mt_words[i]) mt_words[i] = 32'h0;
    end

    // ---------------------------------------------------------------
    // Behavioural twister
    // ---------------------------------------------------------------

    // In-place twist of entry k from entries k, k+1 and k+397, indices wrapping
    function automatic void twist_word(int unsigned k);
        int unsigned nxt;
        int unsigned far_k;
        logic [31:0] y;
        nxt   = (k + 1) % TABLE_DEPTH;
        far_k = (k + FAR_OFFSET) % TABLE_DEPTH;
        y = (mt_words[k] & UPPER_BIT) | (mt_words[nxt] & LOWER_BITS);
        mt_words[k] = mt_words[far_k] ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'h0);
    endfunction

    function automatic logic [31:0] temper_word(logic [31:0] raw);
        logic [31:0] y;
        y = raw;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_MASK_B);
        y = y ^ ((y << 15) & TEMPER_MASK_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Block-specific fill, then one full twist pass that reads entries
    // already rewritten earlier in the same pass
    function automatic void reseed_table(logic [31:0] seed);
        for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
            if (i[0])
                mt_words[i] = seed + i * ODD_STEP;
            else
                mt_words[i] = (EVEN_OFFSET + seed * EVEN_MUL) * i;
        end
        for (int unsigned i = 0; i < TABLE_DEPTH; i++)
            twist_word(i);
        mt_pos = 0;
    endfunction

    // One draw: twist, temper, advance; Q1.31 of y/2^31 - 1 is y with the top bit flipped
    function automatic logic [31:0] next_draw();
        int unsigned k;
        logic [31:0] y;
        k = mt_pos;
        twist_word(k);
        y = temper_word(mt_words[k]);
        mt_pos = (k + 1 == TABLE_DEPTH) ? 0 : k + 1;
        return y ^ UPPER_BIT;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic void queue_item(logic kind, logic [31:0] seed);
        t_mt_item it;
        it.kind = kind;
        it.seed = seed;
        pending_items.push_back(it);
    endfunction

    // Idle cycles before the next transfer: usually a random pick, with occasional
    // runs of back-to-back transfers
    function automatic int pick_wait(ref int quiet_run);
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet_run = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Driver: falling edge. An item is dropped only once its transfer has been
    // seen; a zero gap reloads in the same step so valid stays high throughout.
    always @(negedge clk) begin : drive_items
        t_mt_item next_item;
        logic     hold_valid;
        hold_valid = item_valid;
        if (item_valid && items_taken == items_issued)
            hold_valid = 1'b0;
        if (rst_n && !hold_valid) begin
            if (send_wait > 0) begin
                send_wait--;
            end else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                item_kind <= next_item.kind;
                item_seed <= next_item.seed;
                hold_valid = 1'b1;
                items_issued++;
                send_wait = pick_wait(send_quiet);
            end
        end
        item_valid <= hold_valid;
    end

    // Accepted items update the predicted state; draws queue an expected value
    always @(posedge clk) begin
        if (rst_n && item_valid && !item_stall) begin
            items_taken++;
            if (item_kind == KIND_RESEED)
                reseed_table(item_seed);
            else
                expected_values.push_back(next_draw());
        end
    end

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------

    // Each completed result transfer draws a fresh stall stretch; the stretch
    // runs whether or not a result is pending, so stalls land in every phase
    always @(negedge clk) begin
        if (values_seen != values_acked) begin
            values_acked = values_seen;
            hold_wait = pick_wait(recv_quiet);
        end
        if (hold_wait > 0) begin
            value_stall <= 1'b1;
            hold_wait--;
        end else begin
            value_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : check_values
        logic [31:0] want;
        if (rst_n && value_valid && !value_stall) begin
            values_seen++;
            if (expected_values.size() == 0) begin
                $display("%0t ns: value mismatch, expected none, actual %h", $time, rand_value);
                fail_count++;
            end else begin
                want = expected_values.pop_front();
                if (rand_value !== want) begin
                    $display("%0t ns: value mismatch, expected %h, actual %h",
                             $time, want, rand_value);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial begin : stimulus
        int draws;
        int random_left;

        // Draws on the cleared store: tempered zero, i.e. -1.0
        repeat (3) queue_item(KIND_DRAW, $urandom());
        // Seed extremes, each followed by draws
        queue_item(KIND_RESEED, 32'h0000_0000);
        repeat (2) queue_item(KIND_DRAW, $urandom());
        queue_item(KIND_RESEED, 32'hFFFF_FFFF);
        repeat (2) queue_item(KIND_DRAW, $urandom());
        queue_item(KIND_RESEED, 32'h8000_0000);
        queue_item(KIND_DRAW, 32'hFFFF_FFFF);
        queue_item(KIND_RESEED, 32'h7FFF_FFFF);
        queue_item(KIND_DRAW, 32'h0000_0000);
        // Back-to-back reseeds: only the second should count
        queue_item(KIND_RESEED, $urandom());
        queue_item(KIND_RESEED, $urandom());
        queue_item(KIND_DRAW, $urandom());
        queue_item(KIND_RESEED, 32'h0000_0001);
        repeat (2) queue_item(KIND_DRAW, $urandom());

        // One long run past the end of the store so the index wraps
        queue_item(KIND_RESEED, $urandom());
        repeat (TABLE_DEPTH + 16) queue_item(KIND_DRAW, $urandom());
        random_left = RANDOM_ITEMS - (TABLE_DEPTH + 17);

        // Then short reseed-and-draw runs, now and then a run that carries on
        // from the previous state without a reseed
        while (random_left > 0) begin
            if ($urandom_range(0, 3) != 0) begin
                queue_item(KIND_RESEED, $urandom());
                random_left--;
            end
            draws = $urandom_range(1, 40);
            repeat (draws) queue_item(KIND_DRAW, $urandom());
            random_left -= draws;
        end
        item_total = pending_items.size();

        while (items_taken != item_total) @(posedge clk);
        while (expected_values.size() != 0) @(posedge clk);
        // Then wait out DRAIN_CYCLES to catch any stray result
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop, far beyond the slowest correct run (clearing pass, every reseed,
    // every draw behind the longest gaps and stalls)
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
